// ----- hw/rtl/tnmg_pkg.sv -----
// Shared types, codes and the height conversion table for the normal map generator.
package tnmg_pkg;

  typedef logic [15:0] pow_tab_t [256];

  // Result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [1:0] STAT_DEGEN   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_VERT_SCL  = 2'd1;
  localparam logic [1:0] CFG_HORIZ_SUM = 2'd2;

  // Entry v: f = largest integer with (f/2^17)^10 <= (v/255)^17, entry = (f+1)>>1,
  // saturated. Evaluated exactly with wide integers at elaboration.
  function automatic pow_tab_t build_pow_table();
    logic [319:0] base;
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [18:0]  lo;
    logic [18:0]  hi;
    logic [18:0]  mid;
    logic [18:0]  r;
    pow_tab_t     t;
    base = 320'd1;
    for (int k = 0; k < 17; k++) base = base * 320'd255;
    for (int i = 0; i < 256; i++) begin
      rhs = 320'd1 << 170;
      for (int k = 0; k < 17; k++) rhs = rhs * 320'(i);
      lo = 19'd0;
      hi = 19'd131072;
      for (int it = 0; it < 19; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 19'd1) >> 1;
          lhs = base;
          for (int k = 0; k < 10; k++) lhs = lhs * 320'(mid);
          if (lhs <= rhs) lo = mid;
          else hi = mid - 19'd1;
        end
      end
      r = (lo + 19'd1) >> 1;
      t[i] = (r > 19'd65535) ? 16'hFFFF : r[15:0];
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TABLE = build_pow_table();

endpackage

// ----- hw/rtl/terrain_normal_map_generator_core.sv -----
// Terrain normal map generator: height store plus central-difference normal unit.
// Steps: writes and out-of-map items go straight to the result register; degenerate
//   reads stop after store reads, 2 multiplies and the normalize check; other reads run
//   store reads, 2 multiplies, normalize shifts, 3 squares, a 32-step square root and
//   3 restoring divides.
// Throughput: one item at a time; the next item is taken once the result is in the
//   output register. Reset (rst_n low, synchronous) restores config defaults and
//   empties the result register; height store contents are undefined until written.
module terrain_normal_map_generator_core #(
  parameter int MAX_MAP_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // coord_x[7:0], coord_y[15:8], height_byte[23:16]
  input  logic        in_tuser,   // action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // height_value, normal_x, normal_y, normal_z
  output logic [1:0]  out_tuser   // status
);

  localparam int CW    = $clog2(MAX_MAP_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = MAX_MAP_SIZE * MAX_MAP_SIZE;
  localparam int CAP   = (MAX_MAP_SIZE < 256) ? MAX_MAP_SIZE : 256;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_DLD  = 3'd6;
  localparam logic [2:0] S_DIV  = 3'd7;

  // config
  logic [8:0]  map_size_r;
  logic [15:0] vscale_r;
  logic [15:0] hsum_r;
  logic [8:0]  n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_size_r <= 9'd256;
      vscale_r   <= 16'd256;
      hsum_r     <= 16'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tnmg_pkg::CFG_MAP_SIZE:  map_size_r <= cfg_wdata[8:0];
        tnmg_pkg::CFG_VERT_SCL:  vscale_r   <= cfg_wdata;
        tnmg_pkg::CFG_HORIZ_SUM: hsum_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_size_r < 9'd2) n_eff = 9'd2;
    else if (map_size_r > 9'(CAP)) n_eff = 9'(CAP);
    else n_eff = map_size_r;
  end

  // state
  logic [2:0]  state_r, state_nxt;
  logic        fin_r, fin_nxt;       // result ready to move to output register
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  x_r, x_nxt, y_r, y_nxt;
  logic [7:0]  xm_r, xm_nxt, xp_r, xp_nxt, ym_r, ym_nxt, yp_r, yp_nxt;
  logic [15:0] h_r [5];
  logic [15:0] h_nxt [5];
  logic [32:0] mag_r [3];
  logic [32:0] mag_nxt [3];
  logic [2:0]  neg_r, neg_nxt;
  logic [61:0] acc_r, acc_nxt;
  logic [62:0] v_r, v_nxt, r_r, r_nxt, b_r, b_nxt;
  logic [30:0] len_r, len_nxt;
  logic [45:0] rem_r, rem_nxt;
  logic [14:0] q_r, q_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] res_h_r, res_h_nxt;
  logic [15:0] res_n_r [3];
  logic [15:0] res_n_nxt [3];
  logic [1:0]  res_st_r, res_st_nxt;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [1:0]  out_user_r;

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  tnmg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  function automatic logic [AW-1:0] texel_addr(input logic [7:0] cx, input logic [7:0] cy);
    return AW'(cy) * AW'(MAX_MAP_SIZE) + AW'(cx);
  endfunction

  logic        in_fire;
  logic [7:0]  in_x, in_y, in_hb;
  logic        outside;
  logic        out_free;

  assign in_x     = in_tdata[7:0];
  assign in_y     = in_tdata[15:8];
  assign in_hb    = in_tdata[23:16];
  assign in_tready = (state_r == S_IDLE) && !fin_r;
  assign in_fire  = in_tvalid && in_tready;
  assign outside  = ({1'b0, in_x} >= n_eff) || ({1'b0, in_y} >= n_eff);
  assign out_free = !out_valid_r || out_tready;

  assign ram_we    = in_fire && !in_tuser && !outside;
  assign ram_waddr = texel_addr(in_x, in_y);
  assign ram_wdata = tnmg_pkg::POW_TABLE[in_hb];

  always_comb begin
    unique case (cnt_r)
      3'd1:    ram_raddr = texel_addr(xm_r, y_r);
      3'd2:    ram_raddr = texel_addr(xp_r, y_r);
      3'd3:    ram_raddr = texel_addr(x_r, ym_r);
      3'd4:    ram_raddr = texel_addr(x_r, yp_r);
      default: ram_raddr = texel_addr(x_r, y_r);
    endcase
  end

  // datapath helpers
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [32:0]        mmax;
  logic [29:0]        sq_op;
  logic [63:0]        rb_sum;
  logic [45:0]        trial;
  logic [15:0]        qext;

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cnt_nxt   = cnt_r;
    x_nxt = x_r;  y_nxt = y_r;
    xm_nxt = xm_r; xp_nxt = xp_r; ym_nxt = ym_r; yp_nxt = yp_r;
    h_nxt     = h_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    v_nxt = v_r; r_nxt = r_r; b_nxt = b_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    bit_nxt   = bit_r;
    res_h_nxt = res_h_r;
    res_n_nxt = res_n_r;
    res_st_nxt = res_st_r;

    diff   = '0;
    prod   = '0;
    sq_op  = '0;
    rb_sum = '0;
    trial  = '0;
    qext   = '0;
    mmax   = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];

    if (fin_r && out_free) fin_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_n_nxt[0] = '0;
          res_n_nxt[1] = '0;
          res_n_nxt[2] = '0;
          x_nxt = in_x;
          y_nxt = in_y;
          xm_nxt = (in_x == 8'd0) ? 8'(n_eff - 9'd1) : in_x - 8'd1;
          xp_nxt = ({1'b0, in_x} + 9'd1 == n_eff) ? 8'd0 : in_x + 8'd1;
          ym_nxt = (in_y == 8'd0) ? 8'(n_eff - 9'd1) : in_y - 8'd1;
          yp_nxt = ({1'b0, in_y} + 9'd1 == n_eff) ? 8'd0 : in_y + 8'd1;
          if (outside) begin
            res_h_nxt  = '0;
            res_st_nxt = tnmg_pkg::STAT_OUTSIDE;
            fin_nxt    = 1'b1;
          end else if (!in_tuser) begin
            res_h_nxt  = ram_wdata;
            res_st_nxt = tnmg_pkg::STAT_OK;
            fin_nxt    = 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        // read issued for cnt, data for cnt-1 arrives now
        if (cnt_r != 3'd0) h_nxt[cnt_r - 3'd1] = ram_rdata;
        if (cnt_r == 3'd5) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_MUL: begin
        if (cnt_r == 3'd0) diff = $signed({1'b0, h_r[1]}) - $signed({1'b0, h_r[2]});
        else diff = $signed({1'b0, h_r[3]}) - $signed({1'b0, h_r[4]});
        prod = diff * $signed({1'b0, vscale_r});
        if (cnt_r == 3'd0) begin
          mag_nxt[0] = prod[33] ? 33'(-prod) : prod[32:0];
          neg_nxt[0] = prod[33];
          mag_nxt[1] = {1'b0, hsum_r, 16'd0};
          neg_nxt[1] = 1'b0;
          cnt_nxt    = 3'd1;
        end else begin
          mag_nxt[2] = prod[33] ? 33'(-prod) : prod[32:0];
          neg_nxt[2] = prod[33];
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        if (mmax == '0) begin
          // zero vector: height still reported, normal left at zero
          res_h_nxt  = h_r[0];
          res_st_nxt = tnmg_pkg::STAT_DEGEN;
          fin_nxt    = 1'b1;
          state_nxt  = S_IDLE;
        end else if (mmax[32:30] != 3'd0) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else if (!mmax[29]) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end else begin
          res_h_nxt  = h_r[0];
          res_st_nxt = tnmg_pkg::STAT_OK;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = S_SQ;
        end
      end
      S_SQ: begin
        sq_op   = mag_r[cnt_r[1:0]][29:0];
        acc_nxt = acc_r + 62'(sq_op * sq_op);
        if (cnt_r == 3'd2) begin
          v_nxt     = 63'(acc_nxt);
          r_nxt     = '0;
          b_nxt     = 63'd1 << 62;
          state_nxt = S_SQRT;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      S_SQRT: begin
        rb_sum = 64'(r_r) + 64'(b_r);
        if (64'(v_r) >= rb_sum) begin
          v_nxt = v_r - rb_sum[62:0];
          r_nxt = (r_r >> 1) + b_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        b_nxt = b_r >> 2;
        if (b_r[0]) begin
          len_nxt   = r_nxt[30:0];
          cnt_nxt   = '0;
          state_nxt = S_DLD;
        end
      end
      S_DLD: begin
        rem_nxt   = {1'b0, mag_r[cnt_r[1:0]][29:0], 15'd0} + 46'(len_r);
        q_nxt     = '0;
        bit_nxt   = 4'd14;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        trial = 46'({len_r, 1'b0}) << bit_r;
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          q_nxt   = {q_r[13:0], 1'b1};
        end else begin
          q_nxt   = {q_r[13:0], 1'b0};
        end
        if (bit_r == 4'd0) begin
          qext = {1'b0, q_nxt};
          res_n_nxt[cnt_r[1:0]] = neg_r[cnt_r[1:0]] ? 16'(-qext) : qext;
          if (cnt_r == 3'd2) begin
            fin_nxt   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 3'd1;
            state_nxt = S_DLD;
          end
        end else begin
          bit_nxt = bit_r - 4'd1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      cnt_r   <= cnt_nxt;
      if (fin_r && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
    x_r <= x_nxt;   y_r <= y_nxt;
    xm_r <= xm_nxt; xp_r <= xp_nxt; ym_r <= ym_nxt; yp_r <= yp_nxt;
    h_r     <= h_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    v_r <= v_nxt; r_r <= r_nxt; b_r <= b_nxt;
    len_r   <= len_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    bit_r   <= bit_nxt;
    res_h_r <= res_h_nxt;
    res_n_r <= res_n_nxt;
    res_st_r <= res_st_nxt;
    if (fin_r && out_free) begin
      out_data_r <= {res_n_r[2], res_n_r[1], res_n_r[0], res_h_r};
      out_user_r <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tnmg_pkg::STAT_OUTSIDE |-> out_tdata == '0)
    else $error("outside-map result carries nonzero data");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tnmg_pkg::STAT_DEGEN |-> out_tdata[63:16] == '0)
    else $error("degenerate result carries a nonzero normal");

  a_busy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser && !outside |=> state_r == S_RD)
    else $error("read transfer did not start store reads");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> len_r != '0)
    else $error("divide with zero length");

  a_no_store_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE && !fin_r)
    else $error("store written while busy");

endmodule

// ----- hw/rtl/tnmg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tnmg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/terrain_normal_map_generator_core_tb.sv -----
// Self-checking testbench for the terrain normal map generator core.
module terrain_normal_map_generator_core_tb;

  typedef struct {
    logic [15:0]        height;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         status;
  } normal_res_t;

  // Keeps a shadow height map and predicts every result in order.
  class normal_scoreboard;
    logic [15:0]  pow_lut[256];
    logic [15:0]  heights[65536];
    bit           written[65536];
    int unsigned  map_sz = 256;
    int unsigned  vscale = 256;
    int unsigned  hsum = 512;
    normal_res_t  pending_q[$];
    int           errors = 0;

    function new();
      logic [319:0] scale255;
      logic [319:0] rhs;
      logic [319:0] lhs;
      logic [18:0]  f;
      logic [18:0]  t;
      logic [18:0]  rounded;
      scale255 = 320'd1;
      for (int k = 0; k < 17; k++) scale255 = scale255 * 320'd255;
      for (int v = 0; v < 256; v++) begin
        rhs = 320'd1;
        for (int k = 0; k < 17; k++) rhs = rhs * 320'(v);
        rhs = rhs << 170;
        f = 19'd0;
        // bit-serial search for the largest f with f^10 * 255^17 <= v^17 * 2^170
        for (int b = 17; b >= 0; b--) begin
          t = f | (19'd1 << b);
          lhs = scale255;
          for (int k = 0; k < 10; k++) lhs = lhs * 320'(t);
          if (lhs <= rhs) f = t;
        end
        rounded = (f + 19'd1) >> 1;
        pow_lut[v] = (rounded > 19'd65535) ? 16'hFFFF : rounded[15:0];
      end
    endfunction

    function int unsigned side();
      if (map_sz < 2) return 2;
      if (map_sz > 256) return 256;
      return map_sz;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tnmg_pkg::CFG_MAP_SIZE:  map_sz = int'(val[8:0]);
        tnmg_pkg::CFG_VERT_SCL:  vscale = int'(val);
        tnmg_pkg::CFG_HORIZ_SUM: hsum = int'(val);
        default: ;
      endcase
    endfunction

    function int unsigned wrap(int v);
      int n;
      n = side();
      return (v < 0) ? n - 1 : (v >= n) ? 0 : v;
    endfunction

    function bit is_set(int unsigned x, int unsigned y);
      return written[y * 256 + x];
    endfunction

    // A read is legal if it falls outside the map or if the center and its four wrapped neighbors hold data.
    function bit read_ok(int unsigned x, int unsigned y);
      if (x >= side() || y >= side()) return 1;
      return is_set(x, y) && is_set(wrap(x - 1), y) && is_set(wrap(x + 1), y) &&
             is_set(x, wrap(y - 1)) && is_set(x, wrap(y + 1));
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_input(bit rd, int unsigned x, int unsigned y, logic [7:0] hb);
      normal_res_t     r;
      longint          c[3];
      longint unsigned mg[3];
      longint unsigned mx;
      longint unsigned len;
      longint unsigned q;
      int              dx;
      int              dz;
      r = '{default: '0};
      if (x >= side() || y >= side()) begin
        r.status = tnmg_pkg::STAT_OUTSIDE;
      end else if (!rd) begin
        heights[y * 256 + x] = pow_lut[hb];
        written[y * 256 + x] = 1;
        r.height = pow_lut[hb];
        r.status = tnmg_pkg::STAT_OK;
      end else begin
        dx = int'(heights[y * 256 + wrap(x - 1)]) - int'(heights[y * 256 + wrap(x + 1)]);
        dz = int'(heights[wrap(y - 1) * 256 + x]) - int'(heights[wrap(y + 1) * 256 + x]);
        c[0] = longint'(dx) * longint'(vscale);
        c[1] = longint'(hsum) * 65536;
        c[2] = longint'(dz) * longint'(vscale);
        r.height = heights[y * 256 + x];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          mg[i] = (c[i] < 0) ? -c[i] : c[i];
          if (mg[i] > mx) mx = mg[i];
        end
        if (mx == 0) begin
          r.status = tnmg_pkg::STAT_DEGEN;
        end else begin
          while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
            mx = mx >> 1;
          end
          while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
            mx = mx << 1;
          end
          len = sqrt_floor(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
          for (int i = 0; i < 3; i++) begin
            q = (mg[i] * 32768 + len) / (2 * len);
            if (c[i] < 0) q = -q;
            case (i)
              0: r.nx = q[15:0];
              1: r.ny = q[15:0];
              default: r.nz = q[15:0];
            endcase
          end
          r.status = tnmg_pkg::STAT_OK;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check(logic [63:0] data, logic [1:0] user);
      normal_res_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: tdata=%h tuser=%0d", data, user);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (data[15:0] !== e.height) begin
        $error("height_value: expected %0d, got %0d", e.height, data[15:0]);
        errors++;
      end
      if (data[31:16] !== e.nx) begin
        $error("normal_x: expected %0d, got %0d", e.nx, $signed(data[31:16]));
        errors++;
      end
      if (data[47:32] !== e.ny) begin
        $error("normal_y: expected %0d, got %0d", e.ny, $signed(data[47:32]));
        errors++;
      end
      if (data[63:48] !== e.nz) begin
        $error("normal_z: expected %0d, got %0d", e.nz, $signed(data[63:48]));
        errors++;
      end
      if (user !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, user);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = tnmg_pkg::CFG_MAP_SIZE;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  normal_scoreboard sb = new();
  int               idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  int               quiet_cycles = 0;

  terrain_normal_map_generator_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    case (idle_mode)
      2:       out_tready <= ($urandom_range(99) >= 87);
      3:       out_tready <= ($urandom_range(99) >= 10);
      default: out_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("terrain_normal_map_generator_core_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(bit rd, int unsigned x, int unsigned y, logic [7:0] hb);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 87 : (idle_mode == 3) ? 10 : 0;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rd;
    in_tdata  <= {hb, y[7:0], x[7:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(rd, x, y, hb);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Coordinate near one of a few anchor points so that neighborhoods fill up.
  function automatic int unsigned near_coord();
    int n;
    int base;
    n = sb.side();
    case ($urandom_range(2))
      0:       base = 0;
      1:       base = n / 2;
      default: base = n - 1;
    endcase
    return (base + int'($urandom_range(4)) - 2 + n) % n;
  endfunction

  task automatic random_item();
    int unsigned x;
    int unsigned y;
    int unsigned pick;
    bit          found;
    int unsigned n;
    n = sb.side();
    pick = $urandom_range(99);
    if (pick < 8 && n < 256) begin
      x = $urandom_range(255);
      y = $urandom_range(255, n);
      if ($urandom_range(1)) {x, y} = {y, x};
      send_item(1'($urandom_range(1)), x, y, 8'($urandom_range(255)));
    end else if (pick < 55) begin
      found = 0;
      for (int t = 0; t < 30 && !found; t++) begin
        x = near_coord();
        y = near_coord();
        if (t >= 20) begin
          x = $urandom_range(n - 1);
          y = $urandom_range(n - 1);
        end
        found = sb.read_ok(x, y);
      end
      if (found) send_item(1'b1, x, y, 8'($urandom_range(255)));
      else send_item(1'b0, near_coord(), near_coord(), 8'($urandom_range(255)));
    end else if (pick < 85) begin
      send_item(1'b0, near_coord(), near_coord(), 8'($urandom_range(255)));
    end else begin
      send_item(1'b0, $urandom_range(n - 1), $urandom_range(n - 1), 8'($urandom_range(255)));
    end
  endtask

  int unsigned sizes[12]  = '{4, 2, 0, 511, 256, 7, 16, 1, 3, 300, 9, 12};
  int unsigned vscls[12]  = '{256, 65535, 1, 300, 0, 1000, 65535, 256, 0, 12345, 0, 0};
  int unsigned hsums[12]  = '{512, 65535, 0, 100, 0, 0, 1, 512, 1000, 777, 0, 0};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wrap around the corner of the full-size map
    send_item(1'b0, 0, 0, 8'd255);
    send_item(1'b0, 255, 0, 8'd0);
    send_item(1'b0, 1, 0, 8'd128);
    send_item(1'b0, 0, 255, 8'd1);
    send_item(1'b0, 0, 1, 8'd254);
    send_item(1'b1, 0, 0, 8'hAA);
    // small map: outside coords for both actions, then a filled 2x2 map
    write_reg(tnmg_pkg::CFG_MAP_SIZE, 16'd2);
    send_item(1'b0, 2, 0, 8'd77);
    send_item(1'b1, 255, 255, 8'd0);
    send_item(1'b0, 0, 128, 8'd5);
    send_item(1'b0, 0, 0, 8'd10);
    send_item(1'b0, 1, 0, 8'd200);
    send_item(1'b0, 0, 1, 8'd0);
    send_item(1'b0, 1, 1, 8'd255);
    send_item(1'b1, 0, 0, 8'd0);
    send_item(1'b1, 1, 1, 8'd0);
    send_item(1'b1, 1, 0, 8'd0);
    // all-zero vector: degenerate; then the same read with both registers at full scale
    write_reg(tnmg_pkg::CFG_VERT_SCL, 16'd0);
    write_reg(tnmg_pkg::CFG_HORIZ_SUM, 16'd0);
    send_item(1'b1, 0, 1, 8'd0);
    write_reg(tnmg_pkg::CFG_HORIZ_SUM, 16'hFFFF);
    write_reg(tnmg_pkg::CFG_VERT_SCL, 16'hFFFF);
    send_item(1'b1, 0, 1, 8'd0);

    for (int p = 0; p < 12; p++) begin
      if (p >= 10) begin
        vscls[p] = $urandom_range(65535);
        hsums[p] = $urandom_range(65535);
      end
      write_reg(tnmg_pkg::CFG_MAP_SIZE, 16'(sizes[p]));
      write_reg(tnmg_pkg::CFG_VERT_SCL, 16'(vscls[p]));
      write_reg(tnmg_pkg::CFG_HORIZ_SUM, 16'(hsums[p]));
      idle_mode = p % 4;
      for (int i = 0; i < 46; i++) random_item();
    end

    in_tvalid <= 1'b0;
    idle_mode = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("terrain_normal_map_generator_core_tb: clean");
    end else begin
      $display("terrain_normal_map_generator_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tnmg_pkg.sv
hw/rtl/tnmg_ram.sv
hw/rtl/terrain_normal_map_generator_core.sv
tb/terrain_normal_map_generator_core_tb.sv
